/* design/mjs_pkg.sv */
`default_nettype none
package mjs_pkg;

   localparam int SUM_W        = 64;
   localparam int LG_FRAC_BITS = 32;

   typedef logic [SUM_W-1:0] sum_type;

endpackage
`default_nettype wire

/* design/markov_jsd_best_split_scan_unit.sv */
`default_nettype none
// channel   ports                                         handshake
// request   req_nucleotide, req_last_base                 start && !busy
// response  rsp_best_split, rsp_best_score, rsp_status    rsp_strobe, one cycle
// csr       csr_write_data                                csr_write_enable
//
// Loading accepts one base per cycle while busy is low. A base with last_base starts
// the scan and busy stays high until the result strobe. The scan clears the 80-entry
// count memories, then runs one count update per transition, each with eight runs of
// the serial x*log2(x) unit (32 squaring steps each). Every later split adds a left and a
// right update and a score of five 64-step divisions. A too-short sequence answers with
// status set. Reset is synchronous; the receiver cannot stall the strobe.
module markov_jsd_best_split_scan_unit #(
   parameter int MAX_LENGTH          = 65536,
   parameter int SCORE_FRACTION_BITS = 28
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [1:0]                           req_nucleotide,
   input  wire logic                                 req_last_base,
   output logic                                      rsp_strobe,
   output logic [$clog2(MAX_LENGTH+1)-1:0]           rsp_best_split,
   output logic signed [31:0]                        rsp_best_score,
   output logic                                      rsp_status,
   input  wire logic                                 csr_write_enable,
   input  wire logic [12:0]                          csr_write_data
);
   import mjs_pkg::*;

   localparam int AW   = $clog2(MAX_LENGTH);
   localparam int LW   = $clog2(MAX_LENGTH + 1);
   localparam int CMPW = ((LW > 14) ? LW : 14) + 1;
   localparam int HW   = 40;
   localparam int SHR  = (32 - SCORE_FRACTION_BITS > 0) ? 32 - SCORE_FRACTION_BITS : 0;
   localparam int SHL  = (32 - SCORE_FRACTION_BITS < 0) ? SCORE_FRACTION_BITS - 32 : 0;
   localparam logic [71:0] RND = 72'(SHR > 0) << ((SHR > 0) ? SHR - 1 : 0);
   localparam int ROW_LEN      = 5;
   localparam int TABLE_DEPTH  = 16 * ROW_LEN;
   localparam logic [12:0] MIN_MARGIN   = 13'd3;
   localparam logic [12:0] MARGIN_RESET = 13'd10;

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_DECIDE = 5'd1;
   localparam logic [4:0] ST_SHORT  = 5'd2;
   localparam logic [4:0] ST_CLEAR  = 5'd3;
   localparam logic [4:0] ST_F0     = 5'd4;
   localparam logic [4:0] ST_F1     = 5'd5;
   localparam logic [4:0] ST_F2     = 5'd6;
   localparam logic [4:0] ST_F3     = 5'd7;
   localparam logic [4:0] ST_M0     = 5'd8;
   localparam logic [4:0] ST_M1     = 5'd9;
   localparam logic [4:0] ST_M2     = 5'd10;
   localparam logic [4:0] ST_MW0    = 5'd11;
   localparam logic [4:0] ST_MW1    = 5'd12;
   localparam logic [4:0] ST_XGO    = 5'd13;
   localparam logic [4:0] ST_XWAIT  = 5'd14;
   localparam logic [4:0] ST_NEXT   = 5'd15;
   localparam logic [4:0] ST_SPREP  = 5'd16;
   localparam logic [4:0] ST_MUL0   = 5'd17;
   localparam logic [4:0] ST_MUL1   = 5'd18;
   localparam logic [4:0] ST_DGO    = 5'd19;
   localparam logic [4:0] ST_DWAIT  = 5'd20;
   localparam logic [4:0] ST_CMP    = 5'd21;
   localparam logic [4:0] ST_OUT    = 5'd22;

   localparam logic [1:0] PH_BUILD_L = 2'd0;
   localparam logic [1:0] PH_BUILD_R = 2'd1;
   localparam logic [1:0] PH_SCAN_L  = 2'd2;
   localparam logic [1:0] PH_SCAN_R  = 2'd3;

   localparam logic [2:0] SK_HA = 3'd0;
   localparam logic [2:0] SK_HB = 3'd1;
   localparam logic [2:0] SK_HG = 3'd2;
   localparam logic [2:0] SK_T1 = 3'd3;
   localparam logic [2:0] SK_T2 = 3'd4;

   logic [1:0]    seq_mem [MAX_LENGTH];
   logic [LW-1:0] left_mem [TABLE_DEPTH];
   logic [LW-1:0] right_mem [TABLE_DEPTH];

   logic [4:0]    state_ff, state_in;
   logic [1:0]    phase_ff, phase_in;
   logic [LW-1:0] len_ff, len_in;
   logic [12:0]   margin_ff, margin_in;
   logic [12:0]   me_ff, me_in;
   logic [LW-1:0] idx_ff, idx_in;
   logic [LW-1:0] split_ff, split_in;
   logic          first_ff, first_in;
   logic [6:0]    clr_ff, clr_in;
   logic [1:0]    b0_ff, b0_in, b1_ff, b1_in, b2_ff, b2_in;
   logic [LW-1:0] lt_ff, lt_in, rt_ff, rt_in, lc_ff, lc_in, rc_ff, rc_in;
   logic [2:0]    xk_ff, xk_in;
   logic [2:0]    sk_ff, sk_in;
   sum_type       sum_l_ff, sum_l_in, sum_r_ff, sum_r_in, sum_a_ff, sum_a_in;
   logic [HW-1:0] ha_ff, ha_in, hb_ff, hb_in;
   sum_type       hg_ff, hg_in, t1_ff, t1_in, t2_ff, t2_in;
   sum_type       plo_ff, plo_in, prod_ff, prod_in;
   sum_type       best_ff, best_in;
   logic [LW-1:0] bsplit_ff, bsplit_in;
   logic          strobe_ff, strobe_in;
   logic [LW-1:0] rsplit_ff, rsplit_in;
   logic [31:0]   rscore_ff, rscore_in;
   logic          rstatus_ff, rstatus_in;

   logic [1:0]    seq_q_ff;
   logic [LW-1:0] left_q_ff, right_q_ff;

   logic          seq_we;
   logic [AW-1:0] seq_waddr, seq_raddr;
   logic          left_we, right_we;
   logic [6:0]    cnt_waddr, cnt_raddr;
   logic [LW-1:0] cnt_wdata;

   logic          accept;
   logic [12:0]   me_c;
   logic [3:0]    ctx;
   logic [6:0]    tot_addr, cnt_addr;
   logic          up, side_r;
   logic [LW-1:0] st, ot, sc, oc, st_new, sc_new, at, at_new, ac, ac_new;
   logic [LW-1:0] xop;
   logic          xadd;
   logic          xstart, xdone;
   sum_type       xres;
   logic          dstart, ddone;
   sum_type       dquo, dvd;
   logic [LW-1:0] dvs;
   logic [LW-1:0] mul_a;
   logic [HW-1:0] mul_h;
   logic [LW+31:0] mlo;
   logic [LW+HW-33:0] mhi;
   sum_type       score;
   logic          neg;
   sum_type       mag;
   logic [71:0]   mag_r;
   logic [32:0]   clamp;
   logic [31:0]   score_out;

   mjs_xlg #(.XW(LW)) u_xlg (
      .clock  (clock),
      .reset  (reset),
      .start  (xstart),
      .x      (xop),
      .done   (xdone),
      .result (xres)
   );

   mjs_div #(.VW(LW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dstart),
      .dividend (dvd),
      .divisor  (dvs),
      .done     (ddone),
      .quotient (dquo)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      me_c     = (margin_ff < MIN_MARGIN) ? MIN_MARGIN : margin_ff;
      ctx      = {b0_ff, b1_ff};
      tot_addr = 7'({ctx, 2'b00}) + 7'(ctx);
      cnt_addr = tot_addr + 7'(b2_ff) + 7'd1;
      up       = (phase_ff != PH_SCAN_R);
      side_r   = (phase_ff == PH_BUILD_R) || (phase_ff == PH_SCAN_R);
      st       = side_r ? rt_ff : lt_ff;
      ot       = side_r ? lt_ff : rt_ff;
      sc       = side_r ? rc_ff : lc_ff;
      oc       = side_r ? lc_ff : rc_ff;
      st_new   = up ? LW'(st + 1'b1) : LW'(st - LW'(st != '0));
      sc_new   = up ? LW'(sc + 1'b1) : LW'(sc - LW'(sc != '0));
      at       = LW'(st + ot);
      at_new   = LW'(st_new + ot);
      ac       = LW'(sc + oc);
      ac_new   = LW'(sc_new + oc);
      case (xk_ff)
         3'd0:    xop = st_new;
         3'd1:    xop = st;
         3'd2:    xop = sc_new;
         3'd3:    xop = sc;
         3'd4:    xop = at_new;
         3'd5:    xop = at;
         3'd6:    xop = ac_new;
         default: xop = ac;
      endcase
      xadd = (xk_ff == 3'd0) || (xk_ff == 3'd3) || (xk_ff == 3'd4) || (xk_ff == 3'd7);
   end

   always_comb begin
      case (sk_ff)
         SK_HA: begin
            dvd = sum_l_ff;
            dvs = LW'(split_ff - LW'(2));
         end
         SK_HB: begin
            dvd = sum_r_ff;
            dvs = LW'(len_ff - split_ff - LW'(2));
         end
         SK_HG: begin
            dvd = sum_a_ff;
            dvs = LW'(len_ff - LW'(2));
         end
         default: begin
            dvd = prod_ff;
            dvs = len_ff;
         end
      endcase
      mul_a = (sk_ff == SK_T1) ? split_ff : LW'(len_ff - split_ff);
      mul_h = (sk_ff == SK_T1) ? ha_ff : hb_ff;
      mlo   = {32'd0, mul_a} * {{LW{1'b0}}, mul_h[31:0]};
      mhi   = {{(HW-32){1'b0}}, mul_a} * {{LW{1'b0}}, mul_h[HW-1:32]};
      score = hg_ff - t1_ff - t2_ff;
   end

   always_comb begin
      neg   = best_ff[SUM_W-1];
      mag   = neg ? sum_type'(-best_ff) : best_ff;
      mag_r = ((72'(mag) + RND) >> SHR) << SHL;
      if (mag_r > 72'h0_0000_0000_8000_0000) begin
         clamp = 33'h1_0000_0000 >> 1;
      end else begin
         clamp = mag_r[32:0];
      end
      if (neg) begin
         score_out = 32'(33'd0 - clamp);
      end else if (clamp[31]) begin
         score_out = 32'h7FFF_FFFF;
      end else begin
         score_out = clamp[31:0];
      end
   end

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      len_in     = len_ff;
      margin_in  = csr_write_enable ? csr_write_data : margin_ff;
      me_in      = me_ff;
      idx_in     = idx_ff;
      split_in   = split_ff;
      first_in   = first_ff;
      clr_in     = clr_ff;
      b0_in      = b0_ff;
      b1_in      = b1_ff;
      b2_in      = b2_ff;
      lt_in      = lt_ff;
      rt_in      = rt_ff;
      lc_in      = lc_ff;
      rc_in      = rc_ff;
      xk_in      = xk_ff;
      sk_in      = sk_ff;
      sum_l_in   = sum_l_ff;
      sum_r_in   = sum_r_ff;
      sum_a_in   = sum_a_ff;
      ha_in      = ha_ff;
      hb_in      = hb_ff;
      hg_in      = hg_ff;
      t1_in      = t1_ff;
      t2_in      = t2_ff;
      plo_in     = plo_ff;
      prod_in    = prod_ff;
      best_in    = best_ff;
      bsplit_in  = bsplit_ff;
      strobe_in  = 1'b0;
      rsplit_in  = rsplit_ff;
      rscore_in  = rscore_ff;
      rstatus_in = rstatus_ff;
      seq_we     = 1'b0;
      seq_waddr  = len_ff[AW-1:0];
      seq_raddr  = idx_ff[AW-1:0];
      left_we    = 1'b0;
      right_we   = 1'b0;
      cnt_waddr  = tot_addr;
      cnt_raddr  = tot_addr;
      cnt_wdata  = st_new;
      xstart     = 1'b0;
      dstart     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (len_ff < LW'(MAX_LENGTH)) begin
                  seq_we = 1'b1;
                  len_in = LW'(len_ff + 1'b1);
               end
               if (req_last_base) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            if (CMPW'(len_ff) < (CMPW'(me_c) << 1)) begin
               state_in = ST_SHORT;
            end else begin
               me_in    = me_c;
               clr_in   = '0;
               sum_l_in = '0;
               sum_r_in = '0;
               sum_a_in = '0;
               state_in = ST_CLEAR;
            end
         end
         ST_SHORT: begin
            rsplit_in  = '0;
            rscore_in  = '0;
            rstatus_in = 1'b1;
            strobe_in  = 1'b1;
            len_in     = '0;
            state_in   = ST_IDLE;
         end
         ST_CLEAR: begin
            left_we   = 1'b1;
            right_we  = 1'b1;
            cnt_waddr = clr_ff;
            cnt_wdata = '0;
            clr_in    = clr_ff + 7'd1;
            if (clr_ff == 7'(TABLE_DEPTH - 1)) begin
               phase_in = PH_BUILD_L;
               idx_in   = '0;
               state_in = ST_F0;
            end
         end
         ST_F0: begin
            seq_raddr = idx_ff[AW-1:0];
            state_in  = ST_F1;
         end
         ST_F1: begin
            seq_raddr = AW'(idx_ff + LW'(1));
            b0_in     = seq_q_ff;
            state_in  = ST_F2;
         end
         ST_F2: begin
            seq_raddr = AW'(idx_ff + LW'(2));
            b1_in     = seq_q_ff;
            state_in  = ST_F3;
         end
         ST_F3: begin
            b2_in    = seq_q_ff;
            state_in = ST_M0;
         end
         ST_M0: begin
            cnt_raddr = tot_addr;
            state_in  = ST_M1;
         end
         ST_M1: begin
            cnt_raddr = cnt_addr;
            lt_in     = left_q_ff;
            rt_in     = right_q_ff;
            state_in  = ST_M2;
         end
         ST_M2: begin
            lc_in    = left_q_ff;
            rc_in    = right_q_ff;
            state_in = ST_MW0;
         end
         ST_MW0: begin
            left_we   = !side_r;
            right_we  = side_r;
            cnt_waddr = tot_addr;
            cnt_wdata = st_new;
            state_in  = ST_MW1;
         end
         ST_MW1: begin
            left_we   = !side_r;
            right_we  = side_r;
            cnt_waddr = cnt_addr;
            cnt_wdata = sc_new;
            xk_in     = '0;
            state_in  = ST_XGO;
         end
         ST_XGO: begin
            xstart   = 1'b1;
            state_in = ST_XWAIT;
         end
         ST_XWAIT: begin
            if (xdone) begin
               if (xk_ff[2]) begin
                  sum_a_in = xadd ? sum_a_ff + xres : sum_a_ff - xres;
               end else if (side_r) begin
                  sum_r_in = xadd ? sum_r_ff + xres : sum_r_ff - xres;
               end else begin
                  sum_l_in = xadd ? sum_l_ff + xres : sum_l_ff - xres;
               end
               xk_in = xk_ff + 3'd1;
               if (xk_ff == 3'd7) begin
                  state_in = ST_NEXT;
               end else begin
                  state_in = ST_XGO;
               end
            end
         end
         ST_NEXT: begin
            case (phase_ff)
               PH_BUILD_L: begin
                  if (idx_ff == LW'(LW'(me_ff) - LW'(3))) begin
                     phase_in = PH_BUILD_R;
                     idx_in   = LW'(me_ff);
                  end else begin
                     idx_in = LW'(idx_ff + 1'b1);
                  end
                  state_in = ST_F0;
               end
               PH_BUILD_R: begin
                  if (idx_ff == LW'(len_ff - LW'(3))) begin
                     split_in = LW'(me_ff);
                     first_in = 1'b1;
                     sk_in    = SK_HA;
                     state_in = ST_SPREP;
                  end else begin
                     idx_in   = LW'(idx_ff + 1'b1);
                     state_in = ST_F0;
                  end
               end
               PH_SCAN_L: begin
                  phase_in = PH_SCAN_R;
                  idx_in   = split_ff;
                  state_in = ST_F0;
               end
               default: begin
                  split_in = LW'(split_ff + 1'b1);
                  sk_in    = SK_HA;
                  state_in = ST_SPREP;
               end
            endcase
         end
         ST_SPREP: begin
            if (sk_ff >= SK_T1) begin
               state_in = ST_MUL0;
            end else begin
               state_in = ST_DGO;
            end
         end
         ST_MUL0: begin
            plo_in   = SUM_W'(mlo);
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            prod_in  = plo_ff + (SUM_W'(mhi) << 32);
            state_in = ST_DGO;
         end
         ST_DGO: begin
            dstart   = 1'b1;
            state_in = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (ddone) begin
               case (sk_ff)
                  SK_HA:   ha_in = dquo[HW-1:0];
                  SK_HB:   hb_in = dquo[HW-1:0];
                  SK_HG:   hg_in = dquo;
                  SK_T1:   t1_in = dquo;
                  default: t2_in = dquo;
               endcase
               if (sk_ff == SK_T2) begin
                  state_in = ST_CMP;
               end else begin
                  sk_in    = sk_ff + 3'd1;
                  state_in = ST_SPREP;
               end
            end
         end
         ST_CMP: begin
            if (first_ff || ($signed(score) > $signed(best_ff))) begin
               best_in   = score;
               bsplit_in = split_ff;
            end
            first_in = 1'b0;
            if (split_ff < LW'(len_ff - LW'(me_ff))) begin
               phase_in = PH_SCAN_L;
               idx_in   = LW'(split_ff - LW'(2));
               state_in = ST_F0;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsplit_in  = bsplit_ff;
            rscore_in  = score_out;
            rstatus_in = 1'b0;
            strobe_in  = 1'b1;
            len_in     = '0;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (seq_we) begin
         seq_mem[seq_waddr] <= req_nucleotide;
      end
      seq_q_ff <= seq_mem[seq_raddr];
   end

   always_ff @(posedge clock) begin
      if (left_we) begin
         left_mem[cnt_waddr] <= cnt_wdata;
      end
      if (right_we) begin
         right_mem[cnt_waddr] <= cnt_wdata;
      end
      left_q_ff  <= left_mem[cnt_raddr];
      right_q_ff <= right_mem[cnt_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         len_ff     <= '0;
         margin_ff  <= MARGIN_RESET;
         strobe_ff  <= 1'b0;
         rsplit_ff  <= '0;
         rscore_ff  <= '0;
         rstatus_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         len_ff     <= len_in;
         margin_ff  <= margin_in;
         strobe_ff  <= strobe_in;
         rsplit_ff  <= rsplit_in;
         rscore_ff  <= rscore_in;
         rstatus_ff <= rstatus_in;
      end
      phase_ff  <= phase_in;
      me_ff     <= me_in;
      idx_ff    <= idx_in;
      split_ff  <= split_in;
      first_ff  <= first_in;
      clr_ff    <= clr_in;
      b0_ff     <= b0_in;
      b1_ff     <= b1_in;
      b2_ff     <= b2_in;
      lt_ff     <= lt_in;
      rt_ff     <= rt_in;
      lc_ff     <= lc_in;
      rc_ff     <= rc_in;
      xk_ff     <= xk_in;
      sk_ff     <= sk_in;
      sum_l_ff  <= sum_l_in;
      sum_r_ff  <= sum_r_in;
      sum_a_ff  <= sum_a_in;
      ha_ff     <= ha_in;
      hb_ff     <= hb_in;
      hg_ff     <= hg_in;
      t1_ff     <= t1_in;
      t2_ff     <= t2_in;
      plo_ff    <= plo_in;
      prod_ff   <= prod_in;
      best_ff   <= best_in;
      bsplit_ff <= bsplit_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_best_split = rsplit_ff;
   assign rsp_best_score = rscore_ff;
   assign rsp_status     = rstatus_ff;

endmodule
`default_nettype wire

/* design/mjs_xlg.sv */
`default_nettype none
module mjs_xlg #(
   parameter int XW = 17
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [XW-1:0]   x,
   output logic                 done,
   output mjs_pkg::sum_type     result
);
   import mjs_pkg::*;

   localparam int KW = $clog2(XW);

   localparam logic [2:0] X_IDLE = 3'd0;
   localparam logic [2:0] X_SQ   = 3'd1;
   localparam logic [2:0] X_MUL0 = 3'd2;
   localparam logic [2:0] X_MUL1 = 3'd3;
   localparam logic [2:0] X_DONE = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [XW-1:0]           x_ff, x_in;
   logic [KW-1:0]           k_ff, k_in;
   logic [30:0]             m_ff, m_in;
   logic [LG_FRAC_BITS-1:0] frac_ff, frac_in;
   logic [4:0]              cnt_ff, cnt_in;
   sum_type                 p_ff, p_in;
   sum_type                 result_ff, result_in;

   logic [KW-1:0]           k_calc;
   logic [30:0]             m_init;
   logic [61:0]             sq;
   logic [31:0]             sq_sh;
   logic [XW+31:0]          pf;
   logic [XW+KW-1:0]        pk;

   always_comb begin
      k_calc = '0;
      for (int i = 0; i < XW; i++) begin
         if (x[i]) begin
            k_calc = KW'(i);
         end
      end
      m_init = 31'(x) << (5'd30 - 5'(k_calc));
      sq     = {31'd0, m_ff} * {31'd0, m_ff};
      sq_sh  = sq[61:30];
      pf     = {32'd0, x_ff} * {{XW{1'b0}}, frac_ff};
      pk     = {{KW{1'b0}}, x_ff} * {{XW{1'b0}}, k_ff};
   end

   always_comb begin
      state_in  = state_ff;
      x_in      = x_ff;
      k_in      = k_ff;
      m_in      = m_ff;
      frac_in   = frac_ff;
      cnt_in    = cnt_ff;
      p_in      = p_ff;
      result_in = result_ff;
      unique case (state_ff)
         X_IDLE: begin
            if (start) begin
               x_in    = x;
               k_in    = k_calc;
               m_in    = m_init;
               frac_in = '0;
               cnt_in  = '0;
               if (x < XW'(2)) begin
                  result_in = '0;
                  state_in  = X_DONE;
               end else begin
                  state_in = X_SQ;
               end
            end
         end
         X_SQ: begin
            if (sq_sh[31]) begin
               m_in    = sq_sh[31:1];
               frac_in = {frac_ff[LG_FRAC_BITS-2:0], 1'b1};
            end else begin
               m_in    = sq_sh[30:0];
               frac_in = {frac_ff[LG_FRAC_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = X_MUL0;
            end
         end
         X_MUL0: begin
            p_in     = SUM_W'(pf);
            state_in = X_MUL1;
         end
         X_MUL1: begin
            result_in = p_ff + (SUM_W'(pk) << LG_FRAC_BITS);
            state_in  = X_DONE;
         end
         X_DONE: begin
            state_in = X_IDLE;
         end
         default: begin
            state_in = X_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= X_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff      <= x_in;
      k_ff      <= k_in;
      m_ff      <= m_in;
      frac_ff   <= frac_in;
      cnt_ff    <= cnt_in;
      p_ff      <= p_in;
      result_ff <= result_in;
   end

   assign done   = (state_ff == X_DONE);
   assign result = result_ff;

endmodule
`default_nettype wire

/* design/mjs_div.sv */
`default_nettype none
module mjs_div #(
   parameter int VW = 17
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire mjs_pkg::sum_type dividend,
   input  wire logic [VW-1:0]   divisor,
   output logic                 done,
   output mjs_pkg::sum_type     quotient
);
   import mjs_pkg::*;

   localparam int CW = $clog2(SUM_W);

   localparam logic [1:0] D_IDLE = 2'd0;
   localparam logic [1:0] D_RUN  = 2'd1;
   localparam logic [1:0] D_DONE = 2'd2;

   logic [1:0]    state_ff, state_in;
   sum_type       quo_ff, quo_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [VW:0]   trial;
   logic [VW:0]   diff;

   always_comb begin
      trial = {rem_ff, quo_ff[SUM_W-1]};
      diff  = trial - {1'b0, dvs_ff};
   end

   always_comb begin
      state_in = state_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         D_IDLE: begin
            if (start) begin
               quo_in   = dividend;
               rem_in   = '0;
               dvs_in   = divisor;
               cnt_in   = '0;
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            if (trial >= {1'b0, dvs_ff}) begin
               rem_in = diff[VW-1:0];
               quo_in = {quo_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = trial[VW-1:0];
               quo_in = {quo_ff[SUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(SUM_W - 1)) begin
               state_in = D_DONE;
            end
         end
         D_DONE: begin
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         state_ff <= state_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done     = (state_ff == D_DONE);
   assign quotient = quo_ff;

endmodule
`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

   typedef struct {
      bit [16:0]        split;
      bit signed [31:0] score;
      bit               status;
   } split_result_type;

   class split_scoreboard;
      bit [1:0]         bases[$];
      int unsigned      margin = 10;
      split_result_type expected_splits[$];
      int               errors = 0;

      function longint unsigned log2_q32(int unsigned x);
         int unsigned     t;
         int unsigned     k;
         longint unsigned m;
         longint unsigned r;
         t = x;
         k = 0;
         while (t > 1) begin
            t = t >> 1;
            k++;
         end
         if (k <= 30) m = longint'(x) << (30 - k);
         else m = longint'(x) >> (k - 30);
         r = longint'(k) << 32;
         for (int i = 31; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
               m = m >> 1;
               r = r | (64'd1 << i);
            end
         end
         return r;
      endfunction

      function longint x_log2(int unsigned x);
         if (x < 2) return 0;
         return longint'(longint'(x) * log2_q32(x));
      endfunction

      function longint entropy_sum(int unsigned c[16][5]);
         longint s;
         s = 0;
         for (int k = 0; k < 16; k++) begin
            s += x_log2(c[k][0]);
            for (int b = 1; b < 5; b++) s -= x_log2(c[k][b]);
         end
         return s;
      endfunction

      function longint divergence(int unsigned split_len, int unsigned n);
         int unsigned lc[16][5];
         int unsigned rc[16][5];
         int unsigned gc[16][5];
         int          ctx;
         int          nb;
         longint      ha;
         longint      hb;
         longint      hg;
         for (int k = 0; k < 16; k++)
            for (int b = 0; b < 5; b++) begin
               lc[k][b] = 0;
               rc[k][b] = 0;
            end
         for (int i = 0; i + 2 < n; i++) begin
            ctx = bases[i] * 4 + bases[i + 1];
            nb = bases[i + 2];
            if (i + 2 < split_len) begin
               lc[ctx][0]++;
               lc[ctx][1 + nb]++;
            end else if (i >= split_len) begin
               rc[ctx][0]++;
               rc[ctx][1 + nb]++;
            end
         end
         for (int k = 0; k < 16; k++)
            for (int b = 0; b < 5; b++) gc[k][b] = lc[k][b] + rc[k][b];
         ha = entropy_sum(lc) / longint'(split_len - 2);
         hb = entropy_sum(rc) / longint'(n - split_len - 2);
         hg = entropy_sum(gc) / longint'(n - 2);
         return hg - (longint'(split_len) * ha) / longint'(n)
            - (longint'(n - split_len) * hb) / longint'(n);
      endfunction

      function bit signed [31:0] rescale(longint v);
         longint unsigned mag;
         longint          sv;
         mag = (v < 0) ? longint'(-v) : longint'(v);
         mag = (mag + 8) >> 4;
         if (mag > (64'd1 << 31)) mag = 64'd1 << 31;
         sv = (v < 0) ? -longint'(mag) : longint'(mag);
         if (sv > 64'sd2147483647) sv = 64'sd2147483647;
         return sv[31:0];
      endfunction

      function void note_item(bit [1:0] nuc, bit last);
         split_result_type r;
         int unsigned      n;
         int unsigned      me;
         longint           best;
         longint           s;
         if (bases.size() < 65536) bases = {bases, nuc};
         if (!last) return;
         n = bases.size();
         me = (margin < 3) ? 3 : margin;
         if (n < 2 * me) begin
            r.split = 0;
            r.score = 0;
            r.status = 1;
         end else begin
            best = divergence(me, n);
            r.split = 17'(me);
            for (int unsigned l = me + 1; l <= n - me; l++) begin
               s = divergence(l, n);
               if (s > best) begin
                  best = s;
                  r.split = 17'(l);
               end
            end
            r.score = rescale(best);
            r.status = 0;
         end
         expected_splits = {expected_splits, r};
         bases.delete();
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_result(bit [16:0] split, bit signed [31:0] score, bit status);
         split_result_type e;
         if (expected_splits.size() == 0) begin
            report_mismatch("result with no item pending");
            return;
         end
         e = expected_splits.pop_front();
         if (split !== e.split)
            report_mismatch($sformatf("best_split %0d, want %0d", split, e.split));
         if (score !== e.score)
            report_mismatch($sformatf("best_score %0d, want %0d", score, e.score));
         if (status !== e.status)
            report_mismatch($sformatf("status %0d, want %0d", status, e.status));
      endtask
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              start = 0;
   logic              busy;
   logic [1:0]        req_nucleotide = 0;
   logic              req_last_base = 0;
   logic              rsp_strobe;
   logic [16:0]       rsp_best_split;
   logic signed [31:0] rsp_best_score;
   logic              rsp_status;
   logic              csr_write_enable = 0;
   logic [12:0]       csr_write_data = 0;

   split_scoreboard sb = new();
   int  idle_pct = 0;
   int  items_sent = 0;
   int  quiet_cycles = 0;
   bit  accepted_now;

   always #4 clock = ~clock;

   markov_jsd_best_split_scan_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_nucleotide(req_nucleotide), .req_last_base(req_last_base),
      .rsp_strobe(rsp_strobe), .rsp_best_split(rsp_best_split),
      .rsp_best_score(rsp_best_score), .rsp_status(rsp_status),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always @(posedge clock) begin
      if (!reset) begin
         accepted_now = (start && !busy) || rsp_strobe;
         if (rsp_strobe) sb.check_result(rsp_best_split, rsp_best_score, rsp_status);
         quiet_cycles = accepted_now ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= 400000) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task send_base(bit [1:0] nuc, bit last);
      int gap;
      gap = 0;
      if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         @(negedge clock);
         start = 0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start = 1;
      req_nucleotide = nuc;
      req_last_base = last;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      sb.note_item(nuc, last);
      items_sent++;
   endtask

   task write_margin(bit [12:0] value);
      @(negedge clock);
      start = 0;
      while (sb.expected_splits.size() > 0 || busy) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_write_enable = 1;
      csr_write_data = value;
      sb.margin = value;
      @(negedge clock);
      csr_write_enable = 0;
   endtask

   // pattern: 0 random, 1 constant base, 2 alternating, 3 mostly one base
   task send_sequence(int n, int pattern);
      bit [1:0] nuc;
      bit [1:0] fixed_base;
      fixed_base = 2'($urandom_range(3));
      for (int i = 0; i < n; i++) begin
         case (pattern)
            1: nuc = fixed_base;
            2: nuc = (i % 2) ? 2'd3 : 2'd0;
            3: nuc = ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : fixed_base;
            default: nuc = 2'($urandom_range(3));
         endcase
         send_base(nuc, i == n - 1);
      end
   endtask

   int          me;
   int          n;
   bit [12:0]   margins[] = '{0, 1, 2, 3, 4, 5, 6, 4096, 8191};

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      send_sequence(20, 0);
      write_margin(0);
      send_sequence(6, 1);
      send_sequence(5, 0);
      send_sequence(1, 0);
      send_sequence(8, 2);
      write_margin(4096);
      send_sequence(3, 0);
      write_margin(3);

      while (items_sent < 550) begin
         case ((items_sent / 100) % 4)
            0: idle_pct = 0;
            1: idle_pct = 67;
            2: idle_pct = 0;
            default: idle_pct = 28;
         endcase
         if ($urandom_range(3) == 0) write_margin(margins[$urandom_range(margins.size() - 1)]);
         me = (sb.margin < 3) ? 3 : sb.margin;
         if (me > 8 || $urandom_range(9) == 0) n = $urandom_range(1, (me > 8) ? 12 : 2 * me - 1);
         else n = $urandom_range(2 * me, 2 * me + 20);
         send_sequence(n, ($urandom_range(9) < 6) ? 0 : $urandom_range(1, 3));
      end

      @(negedge clock);
      start = 0;
      while (sb.expected_splits.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* markov_jsd_best_split_scan_unit.f */
design/mjs_pkg.sv
design/mjs_xlg.sv
design/mjs_div.sv
design/markov_jsd_best_split_scan_unit.sv
test/tb_top.sv
